@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHECK_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CHECK_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/atan2pa_pkg.sv @@
// ----------------------------------------------------------------------------
// atan2pa_pkg
// Types and constants for the polynomial atan2 core.
// ----------------------------------------------------------------------------
package atan2pa_pkg;

    localparam int DEFAULT_INPUT_WIDTH     = 16;
    localparam int DEFAULT_ANGLE_FRAC_BITS = 13;

    localparam int ANGLE_W = 16;
    localparam int Q_W     = 16;
    localparam int Z_FRAC  = 15;
    localparam int ACC_W   = 35;

    localparam logic [Q_W-1:0]   Z_ONE       = 16'd32768;
    localparam logic [14:0]      COEF_N1     = 15'd31863;
    localparam logic [12:0]      COEF_N2_MAG = 13'd6290;
    localparam logic [ACC_W-1:0] PI_Q30      = 35'd3373259426;
    localparam logic [ACC_W-1:0] HALF_PI_Q30 = 35'd1686629713;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_DIRECT,
        MODE_SWAPPED
    } mode_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
        logic  y_neg;
        logic  x_neg;
    } ctl_t;

endpackage

@@ rtl/atan2_polynomial_approx_core.sv @@
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_core
// Pipelined fixed-point atan2 using a third-order polynomial on the ratio.
// ----------------------------------------------------------------------------
// Takes one (y, x) transaction per clock and returns its angle with done high
// for one cycle. The pipeline is an entry stage, the 16-bit restoring divider,
// which resolves two quotient bits per stage over eight stages, the three
// multiply stages of the polynomial, a combine stage and a round/saturate
// stage. busy is always low; results cannot be held off.
`include "assert_macros.svh"

module atan2_polynomial_approx_core #(
    parameter int INPUT_WIDTH     = atan2pa_pkg::DEFAULT_INPUT_WIDTH,
    parameter int ANGLE_FRAC_BITS = atan2pa_pkg::DEFAULT_ANGLE_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [INPUT_WIDTH-1:0] y_value,
    input  logic signed [INPUT_WIDTH-1:0] x_value,
    output logic                          done,
    output logic signed [atan2pa_pkg::ANGLE_W-1:0] angle
);

    localparam int W          = INPUT_WIDTH;
    localparam int REM_W      = INPUT_WIDTH + 1;
    localparam int Q_W        = atan2pa_pkg::Q_W;
    localparam int ACC_W      = atan2pa_pkg::ACC_W;
    localparam int ANGLE_W    = atan2pa_pkg::ANGLE_W;
    localparam int STEPS      = 2;
    localparam int DIV_STAGES = Q_W / STEPS;
    localparam int RND_SHIFT  = 30 - ANGLE_FRAC_BITS;

    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (29 - ANGLE_FRAC_BITS));
    localparam logic [ACC_W-1:0] ANGLE_LIM  =
        (atan2pa_pkg::PI_Q30 + ROUND_BIAS) >> RND_SHIFT;
    localparam logic [ANGLE_W-1:0] ANGLE_LIM16 = ANGLE_LIM[ANGLE_W-1:0];

    // ---------------- entry stage ----------------
    logic                 y_neg;
    logic                 x_neg;
    logic [W-1:0]         y_mag;
    logic [W-1:0]         x_mag;
    atan2pa_pkg::ctl_t    s0_ctl_next;
    logic [REM_W-1:0]     s0_rem_next;
    logic [W-1:0]         s0_den_next;
    atan2pa_pkg::ctl_t    s0_ctl_reg;
    logic [REM_W-1:0]     s0_rem_reg;
    logic [W-1:0]         s0_den_reg;

    assign busy = 1'b0;

    always_comb
    begin
        y_neg = y_value[W-1];
        x_neg = x_value[W-1];
        y_mag = y_neg ? (~y_value + 1'b1) : y_value;
        x_mag = x_neg ? (~x_value + 1'b1) : x_value;
        s0_ctl_next.valid = start && !busy;
        s0_ctl_next.y_neg = y_neg;
        s0_ctl_next.x_neg = x_neg;
        if ((x_value != '0) && (x_mag >= y_mag))
        begin
            s0_ctl_next.mode = atan2pa_pkg::MODE_DIRECT;
            s0_rem_next      = {1'b0, y_mag};
            s0_den_next      = x_mag;
        end
        else if (y_value != '0)
        begin
            s0_ctl_next.mode = atan2pa_pkg::MODE_SWAPPED;
            s0_rem_next      = {1'b0, x_mag};
            s0_den_next      = y_mag;
        end
        else
        begin
            s0_ctl_next.mode = atan2pa_pkg::MODE_ZERO;
            s0_rem_next      = '0;
            s0_den_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else
        begin
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_rem_reg <= s0_rem_next;
        s0_den_reg <= s0_den_next;
    end

    // ---------------- divider stages ----------------
    atan2pa_pkg::ctl_t div_ctl_in  [DIV_STAGES];
    logic [REM_W-1:0]  div_rem_in  [DIV_STAGES];
    logic [W-1:0]      div_den_in  [DIV_STAGES];
    logic [Q_W-1:0]    div_q_in    [DIV_STAGES];
    logic [REM_W-1:0]  div_rem_next[DIV_STAGES];
    logic [Q_W-1:0]    div_q_next  [DIV_STAGES];
    atan2pa_pkg::ctl_t div_ctl_reg [DIV_STAGES];
    logic [REM_W-1:0]  div_rem_reg [DIV_STAGES];
    logic [W-1:0]      div_den_reg [DIV_STAGES];
    logic [Q_W-1:0]    div_q_reg   [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        if (g == 0)
        begin : g_first
            assign div_ctl_in[g] = s0_ctl_reg;
            assign div_rem_in[g] = s0_rem_reg;
            assign div_den_in[g] = s0_den_reg;
            assign div_q_in[g]   = '0;
        end
        else
        begin : g_rest
            assign div_ctl_in[g] = div_ctl_reg[g-1];
            assign div_rem_in[g] = div_rem_reg[g-1];
            assign div_den_in[g] = div_den_reg[g-1];
            assign div_q_in[g]   = div_q_reg[g-1];
        end

        logic [REM_W-1:0] rem_v;
        logic [Q_W-1:0]   q_v;
        logic             bit_v;

        always_comb
        begin
            rem_v = div_rem_in[g];
            q_v   = div_q_in[g];
            for (int k = 0; k < STEPS; k++)
            begin
                bit_v = (rem_v >= {1'b0, div_den_in[g]});
                if (bit_v)
                begin
                    rem_v = rem_v - {1'b0, div_den_in[g]};
                end
                q_v   = {q_v[Q_W-2:0], bit_v};
                rem_v = {rem_v[REM_W-2:0], 1'b0};
            end
            div_rem_next[g] = rem_v;
            div_q_next[g]   = q_v;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_ctl_reg[g] <= '0;
            end
            else
            begin
                div_ctl_reg[g] <= div_ctl_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            div_rem_reg[g] <= div_rem_next[g];
            div_den_reg[g] <= div_den_in[g];
            div_q_reg[g]   <= div_q_next[g];
        end
    end

    // ---------------- polynomial stages ----------------
    logic [Q_W-1:0]    zm;
    logic [31:0]       zsq;
    logic [Q_W-1:0]    z2_next;
    logic [28:0]       tprod;
    logic [14:0]       p_next;
    logic [30:0]       pz;
    logic [14:0]       poly_next;

    atan2pa_pkg::ctl_t p1_ctl_reg;
    atan2pa_pkg::ctl_t p2_ctl_reg;
    atan2pa_pkg::ctl_t p3_ctl_reg;
    logic [Q_W-1:0]    z2_reg;
    logic [Q_W-1:0]    zm1_reg;
    logic [Q_W-1:0]    zm2_reg;
    logic [14:0]       p_reg;
    logic [14:0]       poly_reg;

    always_comb
    begin
        zm        = div_q_reg[DIV_STAGES-1];
        zsq       = zm * zm;
        z2_next   = zsq[30:15];
        tprod     = atan2pa_pkg::COEF_N2_MAG * z2_reg;
        p_next    = atan2pa_pkg::COEF_N1 - tprod[28:15];
        pz        = p_reg * zm2_reg;
        poly_next = pz[29:15];
    end

    // ---------------- combine stage ----------------
    logic [ACC_W-1:0]  pq;
    logic [ACC_W-1:0]  pterm;
    logic [ACC_W-1:0]  acc_next;
    logic              zneg;
    atan2pa_pkg::ctl_t acc_ctl_reg;
    logic [ACC_W-1:0]  acc_reg;

    always_comb
    begin
        pq    = {{(ACC_W - 30){1'b0}}, poly_reg, 15'b0};
        zneg  = p3_ctl_reg.y_neg ^ p3_ctl_reg.x_neg;
        pterm = zneg ? (~pq + 1'b1) : pq;
        unique case (p3_ctl_reg.mode)
            atan2pa_pkg::MODE_DIRECT:
            begin
                if (!p3_ctl_reg.x_neg)
                begin
                    acc_next = pterm;
                end
                else if (!p3_ctl_reg.y_neg)
                begin
                    acc_next = atan2pa_pkg::PI_Q30 + pterm;
                end
                else
                begin
                    acc_next = pterm - atan2pa_pkg::PI_Q30;
                end
            end
            atan2pa_pkg::MODE_SWAPPED:
            begin
                if (!p3_ctl_reg.y_neg)
                begin
                    acc_next = atan2pa_pkg::HALF_PI_Q30 - pterm;
                end
                else
                begin
                    acc_next = '0 - atan2pa_pkg::HALF_PI_Q30 - pterm;
                end
            end
            default:
            begin
                acc_next = '0;
            end
        endcase
    end

    // ---------------- round and saturate ----------------
    logic              acc_neg;
    logic [ACC_W-1:0]  acc_mag;
    logic [ACC_W-1:0]  rnd_mag;
    logic [ACC_W-1:0]  sat_mag;
    logic [ACC_W-1:0]  signed_out;
    logic [ANGLE_W-1:0] angle_next;
    logic              done_reg;
    logic [ANGLE_W-1:0] angle_reg;

    always_comb
    begin
        acc_neg    = acc_reg[ACC_W-1];
        acc_mag    = acc_neg ? (~acc_reg + 1'b1) : acc_reg;
        rnd_mag    = (acc_mag + ROUND_BIAS) >> RND_SHIFT;
        sat_mag    = (rnd_mag > ANGLE_LIM) ? ANGLE_LIM : rnd_mag;
        signed_out = acc_neg ? (~sat_mag + 1'b1) : sat_mag;
        angle_next = signed_out[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg  <= '0;
            p2_ctl_reg  <= '0;
            p3_ctl_reg  <= '0;
            acc_ctl_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            p1_ctl_reg  <= div_ctl_reg[DIV_STAGES-1];
            p2_ctl_reg  <= p1_ctl_reg;
            p3_ctl_reg  <= p2_ctl_reg;
            acc_ctl_reg <= p3_ctl_reg;
            done_reg    <= acc_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        z2_reg    <= z2_next;
        zm1_reg   <= zm;
        zm2_reg   <= zm1_reg;
        p_reg     <= p_next;
        poly_reg  <= poly_next;
        acc_reg   <= acc_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

    // ---------------- assertions ----------------
    `CHECK_IMPLIES(a_ratio_bound, clk, rst_n,
        div_ctl_reg[DIV_STAGES-1].valid && div_ctl_reg[DIV_STAGES-1].mode != atan2pa_pkg::MODE_ZERO,
        zm <= atan2pa_pkg::Z_ONE)
    `CHECK_IMPLIES(a_poly_bound, clk, rst_n, p3_ctl_reg.valid,
        poly_reg <= atan2pa_pkg::COEF_N1)
    `CHECK_NEXT(a_done_follows, clk, rst_n, acc_ctl_reg.valid, done)
    `CHECK_IMPLIES(a_angle_sat, clk, rst_n, done,
        (ANGLE_FRAC_BITS > 13) || (($signed(angle) <= $signed(ANGLE_LIM16))
        && ($signed(angle) >= -$signed(ANGLE_LIM16))))

endmodule
